// ===== rtl/core/dltp_pkg.sv =====
// Shared types and constants of the directed link table with weighted pick.
`default_nettype none
package dltp_pkg;

  // Number of nodes; only nodes below SPAN can be named by a 6-bit field.
  localparam int NODES  = 64;
  localparam int NODE_W = 6;
  localparam int ROWS   = 2 ** NODE_W;
  localparam int SPAN   = (NODES < ROWS) ? NODES : ROWS;
  localparam int ROW_W  = ROWS;
  localparam int CNT_W  = 7;
  localparam int TOT_W  = 13;
  localparam int DIFF_W = TOT_W + 1;
  localparam int RV_W   = 32;
  localparam int RVC_W  = 5;

  // Operation codes.
  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_PICK  = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dst_node;
    logic [RV_W-1:0]   random_value;
  } dltp_req_t;

  typedef struct packed {
    logic              link_was_present;
    logic [CNT_W-1:0]  out_degree;
    logic [CNT_W-1:0]  in_degree;
    logic [TOT_W-1:0]  total_links;
    logic [NODE_W-1:0] picked_node;
    logic              pick_valid;
  } dltp_rsp_t;

  // Write request to the link row store.
  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] addr;
    logic [ROW_W-1:0]  data;
  } row_wr_t;

  // Write request to a degree counter store.
  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] addr;
    logic [CNT_W-1:0]  data;
  } cnt_wr_t;

endpackage
`default_nettype wire

// ===== rtl/core/dltp_sub.sv =====
// Shared subtractor used by the modulo steps and the cumulative in-degree walk.
`default_nettype none
module dltp_sub import dltp_pkg::*; (
  input  logic [DIFF_W-1:0] a,
  input  logic [DIFF_W-1:0] b,
  output logic [DIFF_W-1:0] diff,
  output logic              borrow
);

  // Borrow is set when b is greater than a.
  assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule
`default_nettype wire

// ===== rtl/core/dltp_store.sv =====
// Link row memory and the two degree counter memories, with per-entry valid bits.
`default_nettype none
module dltp_store import dltp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  row_wr_t           row_wr,
  input  cnt_wr_t           out_wr,
  input  cnt_wr_t           in_wr,
  input  logic [NODE_W-1:0] row_raddr,
  input  logic [NODE_W-1:0] out_raddr,
  input  logic [NODE_W-1:0] in_raddr,
  output logic [ROW_W-1:0]  row_rdata,
  output logic [CNT_W-1:0]  out_rdata,
  output logic [CNT_W-1:0]  in_rdata
);

  logic [ROW_W-1:0] row_mem [ROWS];
  logic [CNT_W-1:0] out_mem [ROWS];
  logic [CNT_W-1:0] in_mem  [ROWS];

  logic [ROWS-1:0]  row_vld;
  logic [ROWS-1:0]  out_vld;
  logic [ROWS-1:0]  in_vld;

  logic [ROW_W-1:0] row_q;
  logic [CNT_W-1:0] out_q;
  logic [CNT_W-1:0] in_q;
  logic             row_q_vld;
  logic             out_q_vld;
  logic             in_q_vld;

  // Memory writes and registered reads.
  always_ff @(posedge clk) begin
    if (row_wr.we) begin
      row_mem[row_wr.addr] <= row_wr.data;
    end
    if (out_wr.we) begin
      out_mem[out_wr.addr] <= out_wr.data;
    end
    if (in_wr.we) begin
      in_mem[in_wr.addr] <= in_wr.data;
    end
    row_q <= row_mem[row_raddr];
    out_q <= out_mem[out_raddr];
    in_q  <= in_mem[in_raddr];
  end

  // Valid bits: an entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld   <= '0;
      out_vld   <= '0;
      in_vld    <= '0;
      row_q_vld <= 1'b0;
      out_q_vld <= 1'b0;
      in_q_vld  <= 1'b0;
    end else begin
      if (row_wr.we) begin
        row_vld[row_wr.addr] <= 1'b1;
      end
      if (out_wr.we) begin
        out_vld[out_wr.addr] <= 1'b1;
      end
      if (in_wr.we) begin
        in_vld[in_wr.addr] <= 1'b1;
      end
      row_q_vld <= row_vld[row_raddr];
      out_q_vld <= out_vld[out_raddr];
      in_q_vld  <= in_vld[in_raddr];
    end
  end

  assign row_rdata = row_q_vld ? row_q : '0;
  assign out_rdata = out_q_vld ? out_q : '0;
  assign in_rdata  = in_q_vld  ? in_q  : '0;

endmodule
`default_nettype wire

// ===== rtl/core/directed_link_table_with_weighted_pick_core.sv =====
// Top level: sequencer of the directed link table with in-degree weighted pick.
//
//   channel   | ports                  | handshake
//   ----------+------------------------+-----------------------------------------
//   item in   | start, busy, request   | taken at an edge with start high, busy low
//   result    | done, response         | done high for one cycle, always taken
//
// Set, clear and query step through the read, update, re-read and capture states to
// the done strobe. A pick with links then runs a one-bit-a-cycle modulo on the shared
// subtractor, primes the in-degree read and walks the nodes one per cycle. Synchronous
// reset clears the sequencer, the link total and the memory valid bits at once. The
// receiver cannot stall; busy is high from the accepting edge until the cycle after
// the done strobe.
`default_nettype none
module directed_link_table_with_weighted_pick_core import dltp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  dltp_req_t request,
  output logic      done,
  output dltp_rsp_t response
);

  // Sequencer state codes.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_RDS  = 3'd3;
  localparam logic [2:0] ST_CAP  = 3'd4;
  localparam logic [2:0] ST_MOD  = 3'd5;
  localparam logic [2:0] ST_WALK = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  localparam logic [NODE_W:0]   SPAN_V = (NODE_W + 1)'(SPAN);
  localparam logic [NODE_W-1:0] LAST_V = NODE_W'(SPAN - 1);

  logic [2:0]        state;
  logic [1:0]        op_q;
  logic [NODE_W-1:0] src_q;
  logic [NODE_W-1:0] dst_q;
  logic [RV_W-1:0]   rv_q;
  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  rem;
  logic [RVC_W-1:0]  bit_cnt;
  logic [NODE_W-1:0] walk_idx;
  logic [NODE_W-1:0] walk_prev;
  logic              walk_live;
  dltp_rsp_t         rsp_q;

  row_wr_t           row_wr;
  cnt_wr_t           out_wr;
  cnt_wr_t           in_wr;
  logic [NODE_W-1:0] in_raddr;
  logic [ROW_W-1:0]  row_rd;
  logic [CNT_W-1:0]  out_rd;
  logic [CNT_W-1:0]  in_rd;

  logic [DIFF_W-1:0] sub_a;
  logic [DIFF_W-1:0] sub_b;
  logic [DIFF_W-1:0] sub_diff;
  logic              sub_borrow;

  logic              accept;
  logic              src_ok;
  logic              dst_ok;
  logic              present;
  logic              do_set;
  logic              do_clr;
  logic [ROW_W-1:0]  dst_bit;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign done   = (state == ST_FIN);
  assign response = rsp_q;

  // Node range checks and link decode of the current item.
  assign src_ok  = ({1'b0, src_q} < SPAN_V);
  assign dst_ok  = ({1'b0, dst_q} < SPAN_V);
  assign dst_bit = ROW_W'(1) << dst_q;
  assign present = src_ok && dst_ok && row_rd[dst_q];
  assign do_set  = (state == ST_UPD) && (op_q == OP_SET) && src_ok && dst_ok && !present;
  assign do_clr  = (state == ST_UPD) && (op_q == OP_CLEAR) && present;

  // Store read addresses: the in-degree port serves dst, src and the walk in turn.
  always_comb begin
    case (state)
      ST_READ: in_raddr = dst_q;
      ST_WALK: in_raddr = walk_idx;
      default: in_raddr = src_q;
    endcase
  end

  // Store writes for a set or clear that changes the link.
  always_comb begin
    row_wr.we   = do_set || do_clr;
    row_wr.addr = src_q;
    row_wr.data = do_set ? (row_rd | dst_bit) : (row_rd & ~dst_bit);
    out_wr.we   = do_set || do_clr;
    out_wr.addr = src_q;
    out_wr.data = do_set ? (out_rd + CNT_W'(1)) : (out_rd - CNT_W'(1));
    in_wr.we    = do_set || do_clr;
    in_wr.addr  = dst_q;
    in_wr.data  = do_set ? (in_rd + CNT_W'(1)) : (in_rd - CNT_W'(1));
  end

  // Operand selection for the shared subtractor.
  always_comb begin
    if (state == ST_MOD) begin
      sub_a = {rem, rv_q[RV_W-1]};
      sub_b = {1'b0, total};
    end else begin
      sub_a = {1'b0, rem};
      sub_b = DIFF_W'(in_rd);
    end
  end

  dltp_store u_store (
    .clk       (clk),
    .rst       (rst),
    .row_wr    (row_wr),
    .out_wr    (out_wr),
    .in_wr     (in_wr),
    .row_raddr (src_q),
    .out_raddr (src_q),
    .in_raddr  (in_raddr),
    .row_rdata (row_rd),
    .out_rdata (out_rd),
    .in_rdata  (in_rd)
  );

  dltp_sub u_sub (
    .a      (sub_a),
    .b      (sub_b),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  // Sequencer control state and link total.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      total <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_READ;
          end
        end
        ST_READ: state <= ST_UPD;
        ST_UPD: begin
          if (do_set) begin
            total <= total + TOT_W'(1);
          end else if (do_clr) begin
            total <= total - TOT_W'(1);
          end
          state <= ST_RDS;
        end
        ST_RDS: state <= ST_CAP;
        ST_CAP: begin
          if ((op_q == OP_PICK) && (total != '0)) begin
            state <= ST_MOD;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_MOD: begin
          if (bit_cnt == '0) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (walk_live && (sub_borrow || (walk_prev == LAST_V))) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Item registers, modulo and walk datapath, and the result register.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          op_q              <= request.op;
          src_q             <= request.src_node;
          dst_q             <= request.dst_node;
          rv_q              <= request.random_value;
          rsp_q.picked_node <= '0;
          rsp_q.pick_valid  <= 1'b0;
        end
      end
      ST_UPD: rsp_q.link_was_present <= present;
      ST_CAP: begin
        rsp_q.out_degree  <= src_ok ? out_rd : '0;
        rsp_q.in_degree   <= src_ok ? in_rd : '0;
        rsp_q.total_links <= total;
        rem               <= '0;
        bit_cnt           <= RVC_W'(RV_W - 1);
      end
      ST_MOD: begin
        // One restoring step per cycle: bring in the next bit of the random value.
        rem       <= sub_borrow ? sub_a[TOT_W-1:0] : sub_diff[TOT_W-1:0];
        rv_q      <= rv_q << 1;
        bit_cnt   <= bit_cnt - RVC_W'(1);
        walk_idx  <= '0;
        walk_live <= 1'b0;
      end
      ST_WALK: begin
        // The node whose in-degree exceeds what is left of r is the pick.
        walk_idx  <= walk_idx + NODE_W'(1);
        walk_prev <= walk_idx;
        walk_live <= 1'b1;
        if (walk_live) begin
          if (sub_borrow) begin
            rsp_q.picked_node <= walk_prev;
            rsp_q.pick_valid  <= 1'b1;
          end else begin
            rem <= sub_diff[TOT_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  // Every accepted item makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("block not busy after an accepted item");

  // The result strobe lasts one cycle and is followed by an idle block.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("result strobe not followed by an idle cycle");

  // A pick succeeds exactly when the table holds links.
  a_pick_outcome: assert property (@(posedge clk) disable iff (rst)
    (done && (op_q == OP_PICK)) |-> (response.pick_valid == (response.total_links != '0)))
    else $error("pick outcome does not match the link total");

  // Results of set, clear and query never carry a pick.
  a_no_stray_pick: assert property (@(posedge clk) disable iff (rst)
    (done && (op_q != OP_PICK)) |-> (!response.pick_valid && (response.picked_node == '0)))
    else $error("pick fields set on a non-pick item");
`endif

endmodule
`default_nettype wire

// ===== test/dltp_link_checker.sv =====
// Checker for the directed link table core: mirrors the table and checks every result item.
`default_nettype none
module dltp_link_checker import dltp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      busy,
  input  dltp_req_t request,
  input  logic      done,
  input  dltp_rsp_t response,
  output int        mismatches,
  output int        results_owed,
  output int        checked,
  output int        peak_degree
);

  // Shadow copy of the link table and its counters.
  logic [ROW_W-1:0] row_bits  [ROWS];
  logic [CNT_W-1:0] in_count  [ROWS];
  logic [CNT_W-1:0] out_count [ROWS];
  logic [TOT_W-1:0] link_count;

  dltp_rsp_t owed_rsp_q[$];
  dltp_rsp_t want;
  int        fail_tally;
  int        check_tally;
  int        peak;
  int        idx;

  // Apply one item to the shadow table and return the result it should give.
  function automatic dltp_rsp_t apply_link_item(input dltp_req_t item);
    dltp_rsp_t   rsp;
    logic        ends_ok;
    logic        hit;
    logic [31:0] r;
    logic [31:0] cum;
    logic        found;
    rsp     = '0;
    ends_ok = (int'(item.src_node) < SPAN) && (int'(item.dst_node) < SPAN);
    hit     = ends_ok && row_bits[item.src_node][item.dst_node];
    case (item.op)
      OP_SET: begin
        if (ends_ok && !hit) begin
          row_bits[item.src_node][item.dst_node] = 1'b1;
          out_count[item.src_node] = out_count[item.src_node] + CNT_W'(1);
          in_count[item.dst_node]  = in_count[item.dst_node] + CNT_W'(1);
          link_count = link_count + TOT_W'(1);
        end
      end
      OP_CLEAR: begin
        if (ends_ok && hit) begin
          row_bits[item.src_node][item.dst_node] = 1'b0;
          out_count[item.src_node] = out_count[item.src_node] - CNT_W'(1);
          in_count[item.dst_node]  = in_count[item.dst_node] - CNT_W'(1);
          link_count = link_count - TOT_W'(1);
        end
      end
      OP_PICK: begin
        // Walk the cumulative in-degrees until the sum passes the reduced value.
        if (link_count != '0) begin
          r     = item.random_value % 32'(link_count);
          cum   = '0;
          found = 1'b0;
          for (int i = 0; i < SPAN; i++) begin
            if (!found) begin
              cum = cum + 32'(in_count[i]);
              if (cum > r) begin
                rsp.picked_node = NODE_W'(i);
                rsp.pick_valid  = 1'b1;
                found = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    rsp.link_was_present = hit;
    rsp.total_links      = link_count;
    if (int'(item.src_node) < SPAN) begin
      rsp.out_degree = out_count[item.src_node];
      rsp.in_degree  = in_count[item.src_node];
      if (int'(rsp.out_degree) > peak) peak = int'(rsp.out_degree);
      if (int'(rsp.in_degree) > peak) peak = int'(rsp.in_degree);
    end
    return rsp;
  endfunction

  // Results are compared before the item taken at the same edge is predicted.
  always @(posedge clk) begin
    if (rst) begin
      for (idx = 0; idx < ROWS; idx++) begin
        row_bits[idx]  = '0;
        in_count[idx]  = '0;
        out_count[idx] = '0;
      end
      link_count = '0;
      owed_rsp_q.delete();
    end else begin
      if (done) begin
        if (owed_rsp_q.size() == 0) begin
          fail_tally++;
          if (fail_tally <= 10)
            $display("%0t: result item with none outstanding: present=%0b out=%0d in=%0d",
                     $realtime, response.link_was_present, response.out_degree,
                     response.in_degree);
        end else begin
          want = owed_rsp_q.pop_front();
          check_tally++;
          if (response.link_was_present !== want.link_was_present ||
              response.out_degree !== want.out_degree ||
              response.in_degree !== want.in_degree ||
              response.total_links !== want.total_links ||
              response.picked_node !== want.picked_node ||
              response.pick_valid !== want.pick_valid) begin
            fail_tally++;
            if (fail_tally <= 10) begin
              $display("%0t: result %0d mismatch", $realtime, check_tally);
              $display("  expected present=%0b out=%0d in=%0d total=%0d picked=%0d valid=%0b",
                       want.link_was_present, want.out_degree, want.in_degree,
                       want.total_links, want.picked_node, want.pick_valid);
              $display("  actual   present=%0b out=%0d in=%0d total=%0d picked=%0d valid=%0b",
                       response.link_was_present, response.out_degree, response.in_degree,
                       response.total_links, response.picked_node, response.pick_valid);
            end
          end
        end
      end
      if (start && !busy)
        owed_rsp_q.push_back(apply_link_item(request));
    end
    mismatches   <= fail_tally;
    results_owed <= owed_rsp_q.size();
    checked      <= check_tally;
    peak_degree  <= peak;
  end

endmodule
`default_nettype wire

// ===== test/directed_link_table_with_weighted_pick_core_tb.sv =====
// Testbench top for the directed link table core: stimulus, watchdog and verdict.
`default_nettype none
module directed_link_table_with_weighted_pick_core_tb;
  import dltp_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic      clk     = 1'b0;
  logic      rst     = 1'b1;
  logic      start   = 1'b0;
  dltp_req_t request = '0;
  logic      busy;
  logic      done;
  dltp_rsp_t response;

  int mismatches;
  int results_owed;
  int checked;
  int peak_degree;
  int quiet_cycles;
  int op_tally [4];
  logic calm = 1'b0;

  directed_link_table_with_weighted_pick_core dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .done     (done),
    .response (response)
  );

  dltp_link_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .done         (done),
    .response     (response),
    .mismatches   (mismatches),
    .results_owed (results_owed),
    .checked      (checked),
    .peak_degree  (peak_degree)
  );

  always #5 clk = ~clk;

  // Give up when neither channel has moved for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("directed_link_table_with_weighted_pick_core_tb: FAIL");
        $finish;
      end
    end
  end

  function automatic dltp_req_t link_item(input logic [1:0] op, input int s, input int d,
                                          input logic [RV_W-1:0] rv);
    dltp_req_t item;
    item.op           = op;
    item.src_node     = NODE_W'(s);
    item.dst_node     = NODE_W'(d);
    item.random_value = rv;
    return item;
  endfunction

  // Mostly a small pool of nodes so that links are hit again and cleared.
  function automatic dltp_req_t random_link_item();
    dltp_req_t item;
    int        roll;
    roll = $urandom_range(99);
    if (roll < 35)      item.op = OP_SET;
    else if (roll < 60) item.op = OP_CLEAR;
    else if (roll < 75) item.op = OP_QUERY;
    else                item.op = OP_PICK;
    item.src_node = ($urandom_range(99) < 60) ? NODE_W'($urandom_range(7))
                                              : NODE_W'($urandom_range(ROWS - 1));
    item.dst_node = ($urandom_range(99) < 60) ? NODE_W'($urandom_range(7))
                                              : NODE_W'($urandom_range(ROWS - 1));
    roll = $urandom_range(99);
    if (roll < 10)      item.random_value = '0;
    else if (roll < 20) item.random_value = '1;
    else if (roll < 35) item.random_value = RV_W'($urandom_range(15));
    else                item.random_value = $urandom;
    return item;
  endfunction

  // Present one item until the block takes it, then perhaps idle for a while.
  task automatic send_item(input dltp_req_t item);
    start   <= 1'b1;
    request <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    op_tally[item.op]++;
    if (!calm && $urandom_range(99) < 21) begin
      start <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
  endtask

  initial begin
    int hub;
    int sink;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed items: empty table, corner nodes, repeated and absent links, pick extremes.
    send_item(link_item(OP_QUERY, 0, 0, '0));
    send_item(link_item(OP_PICK, 0, 0, '1));
    send_item(link_item(OP_SET, 0, 0, '0));
    send_item(link_item(OP_SET, 63, 63, '1));
    send_item(link_item(OP_SET, 0, 63, 32'h5555_5555));
    send_item(link_item(OP_SET, 63, 0, 32'hAAAA_AAAA));
    send_item(link_item(OP_SET, 0, 63, '0));
    send_item(link_item(OP_QUERY, 0, 63, '0));
    send_item(link_item(OP_QUERY, 63, 62, '0));
    send_item(link_item(OP_PICK, 0, 0, '0));
    send_item(link_item(OP_PICK, 63, 63, '1));
    send_item(link_item(OP_PICK, 0, 0, 32'd1));
    send_item(link_item(OP_PICK, 0, 0, 32'd2));
    send_item(link_item(OP_PICK, 0, 0, 32'd3));
    send_item(link_item(OP_CLEAR, 0, 63, '0));
    send_item(link_item(OP_CLEAR, 0, 63, '0));
    send_item(link_item(OP_CLEAR, 42, 21, '0));
    send_item(link_item(OP_QUERY, 63, 63, '0));
    send_item(link_item(OP_PICK, 63, 0, 32'h8000_0001));
    send_item(link_item(OP_CLEAR, 0, 0, '0));
    send_item(link_item(OP_CLEAR, 63, 63, '0));
    send_item(link_item(OP_CLEAR, 63, 0, '0));
    send_item(link_item(OP_PICK, 0, 0, 32'd5));
    send_item(link_item(OP_QUERY, 0, 0, '0));

    // Fill one whole row and one whole column so the degrees reach their maximum.
    hub = $urandom_range(ROWS - 1);
    for (int i = 0; i < ROWS; i++)
      send_item(link_item(OP_SET, hub, i, $urandom));
    sink = $urandom_range(ROWS - 1);
    for (int i = 0; i < ROWS; i++)
      send_item(link_item(OP_SET, i, sink, $urandom));
    send_item(link_item(OP_QUERY, sink, sink, '0));

    // Random mix over a well populated table, with one stretch of back-to-back items.
    for (int k = 0; k < 220; k++) begin
      calm = (k >= 100 && k < 180);
      send_item(random_link_item());
    end
    calm = 1'b0;

    // Drain the full row again, picking now and then as the total falls.
    for (int i = 0; i < ROWS; i++) begin
      send_item(link_item(OP_CLEAR, hub, i, '0));
      if (i % 16 == 15)
        send_item(link_item(OP_PICK, hub, i, $urandom));
    end

    start <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (120) @(posedge clk);

    $display("Sent %0d set, %0d clear, %0d query and %0d pick items; %0d results checked.",
             op_tally[OP_SET], op_tally[OP_CLEAR], op_tally[OP_QUERY], op_tally[OP_PICK],
             checked);
    $display("Highest node degree reached was %0d; %0d mismatches.", peak_degree, mismatches);
    if (mismatches == 0) begin
      $display("directed_link_table_with_weighted_pick_core_tb: PASS");
    end else begin
      $display("directed_link_table_with_weighted_pick_core_tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== directed_link_table_with_weighted_pick_core.f =====
rtl/core/dltp_pkg.sv
rtl/core/dltp_sub.sv
rtl/core/dltp_store.sv
rtl/core/directed_link_table_with_weighted_pick_core.sv
test/dltp_link_checker.sv
test/directed_link_table_with_weighted_pick_core_tb.sv
